// ----- src/jpeg_marker_segmenter_top_defines.svh -----
// assertion macros shared by the marker segmenter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef JPEG_MARKER_SEGMENTER_TOP_DEFINES_SVH
`define JPEG_MARKER_SEGMENTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define JMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define JMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/jms_pkg.sv -----
// shared types and constants of the jpeg marker segmenter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jms_pkg;

    // parser mode
    typedef enum logic [1:0] {
        MODE_DATA,
        MODE_FF,
        MODE_CODE,
        MODE_DONE
    } t_mode;

    // result kind
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_MARK,
        KIND_BAD,
        KIND_EOI
    } t_kind;

    // segment classes
    localparam logic [3:0] CLS_PREAMBLE = 4'd0;
    localparam logic [3:0] CLS_SOI      = 4'd1;
    localparam logic [3:0] CLS_SOF0     = 4'd2;
    localparam logic [3:0] CLS_SOF2     = 4'd3;
    localparam logic [3:0] CLS_DHT      = 4'd4;
    localparam logic [3:0] CLS_DQT      = 4'd5;
    localparam logic [3:0] CLS_DRI      = 4'd6;
    localparam logic [3:0] CLS_SOS      = 4'd7;
    localparam logic [3:0] CLS_COM      = 4'd8;
    localparam logic [3:0] CLS_RST      = 4'd9;
    localparam logic [3:0] CLS_APP      = 4'd10;

    // byte values and marker codes
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_00   = 8'h00;
    localparam logic [7:0] CODE_SOI  = 8'hD8;
    localparam logic [7:0] CODE_EOI  = 8'hD9;
    localparam logic [7:0] CODE_SOF0 = 8'hC0;
    localparam logic [7:0] CODE_SOF2 = 8'hC2;
    localparam logic [7:0] CODE_DHT  = 8'hC4;
    localparam logic [7:0] CODE_DQT  = 8'hDB;
    localparam logic [7:0] CODE_DRI  = 8'hDD;
    localparam logic [7:0] CODE_SOS  = 8'hDA;
    localparam logic [7:0] CODE_RST0 = 8'hD0;
    localparam logic [7:0] CODE_APP0 = 8'hE0;
    localparam logic [7:0] CODE_COM  = 8'hFE;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

endpackage

// ----- src/jms_classify.sv -----
// marker code classifier: segment class and number of a marker code
// depends on jms_pkg
`timescale 1ns / 1ps

module jms_classify
    import jms_pkg::*;
(
    input  logic [7:0] i_code,
    output logic [3:0] o_class,
    output logic [3:0] o_number
);

    // range classes first, then single codes; unknown gives preamble
    always_comb begin
        o_number = 4'd0;
        if (i_code[7:3] == CODE_RST0[7:3]) begin
            o_class  = CLS_RST;
            o_number = {1'b0, i_code[2:0]};
        end else if (i_code[7:4] == CODE_APP0[7:4]) begin
            o_class  = CLS_APP;
            o_number = i_code[3:0];
        end else begin
            case (i_code)
                CODE_SOI:  o_class = CLS_SOI;
                CODE_SOF0: o_class = CLS_SOF0;
                CODE_SOF2: o_class = CLS_SOF2;
                CODE_DHT:  o_class = CLS_DHT;
                CODE_DQT:  o_class = CLS_DQT;
                CODE_DRI:  o_class = CLS_DRI;
                CODE_SOS:  o_class = CLS_SOS;
                CODE_COM:  o_class = CLS_COM;
                default:   o_class = CLS_PREAMBLE;
            endcase
        end
    end

endmodule

// ----- src/jpeg_marker_segmenter_top.sv -----
// path: an accepted byte passes the input register, then the result register
// throughput: one byte per cycle if no result stalls; a resultless byte frees its slot at once
// the result register is the only stall point; input ready follows its state
// reset: synchronous, active low; clears mode, segment class, number, position and valids
// depends on jms_pkg and jms_classify
`timescale 1ns / 1ps

module jpeg_marker_segmenter_top
    import jms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_seg_class,
    output logic [3:0]  o_seg_number,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_pos
);

    // input register
    logic        r_s1_vld;
    logic [7:0]  r_s1_byte;

    // parser state
    t_mode       r_mode, n_mode;
    logic [3:0]  r_class, n_class;
    logic [3:0]  r_number, n_number;
    logic [15:0] r_pos, n_pos;

    // result register
    logic        r_o_vld;
    t_kind       r_o_kind;
    logic [3:0]  r_o_class;
    logic [3:0]  r_o_number;
    logic [7:0]  r_o_byte;
    logic [15:0] r_o_pos;

    // combinational result
    logic        w_has_res;
    t_kind       w_kind;
    logic [3:0]  w_class;
    logic [3:0]  w_number;
    logic [7:0]  w_byte;
    logic [15:0] w_pos;

    logic [3:0]  w_mk_class;
    logic [3:0]  w_mk_number;
    logic        w_out_free;
    logic        w_step;
    logic        w_is_mark;

    jms_classify u_classify (
        .i_code   (r_s1_byte),
        .o_class  (w_mk_class),
        .o_number (w_mk_number)
    );

    // handshake and advance
    assign w_out_free = !r_o_vld || i_out_ready;
    assign w_step     = r_s1_vld && (w_out_free || !w_has_res);
    assign o_in_ready = !r_s1_vld || w_step;

    // a marker code is taken in code mode, or after 0xFF unless stuffed
    assign w_is_mark = (r_mode == MODE_CODE) ||
                       ((r_mode == MODE_FF) && (r_s1_byte != BYTE_00));

    // next parser mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_DATA: begin
                if (r_s1_byte == BYTE_FF) begin
                    n_mode = MODE_FF;
                end
            end
            MODE_FF, MODE_CODE: begin
                if (w_is_mark) begin
                    if (r_s1_byte == CODE_EOI) begin
                        n_mode = MODE_DONE;
                    end else if (w_mk_class == CLS_PREAMBLE) begin
                        n_mode = MODE_CODE;
                    end else begin
                        n_mode = MODE_DATA;
                    end
                end else begin
                    n_mode = MODE_DATA;
                end
            end
            MODE_DONE: n_mode = MODE_DONE;
            default:   n_mode = MODE_DATA;
        endcase
    end

    // result fields and segment bookkeeping
    always_comb begin
        w_has_res = 1'b0;
        w_kind    = KIND_DATA;
        w_class   = r_class;
        w_number  = r_number;
        w_byte    = r_s1_byte;
        w_pos     = r_pos;
        n_class   = r_class;
        n_number  = r_number;
        n_pos     = r_pos;
        if (r_mode == MODE_DONE) begin
            w_has_res = 1'b0;
        end else if (w_is_mark) begin
            w_has_res = 1'b1;
            w_pos     = 16'd0;
            if (r_s1_byte == CODE_EOI) begin
                w_kind   = KIND_EOI;
                w_class  = CLS_PREAMBLE;
                w_number = 4'd0;
            end else if (w_mk_class == CLS_PREAMBLE) begin
                w_kind   = KIND_BAD;
                w_class  = CLS_PREAMBLE;
                w_number = 4'd0;
            end else begin
                w_kind   = KIND_MARK;
                w_class  = w_mk_class;
                w_number = w_mk_number;
                n_class  = w_mk_class;
                n_number = w_mk_number;
                n_pos    = 16'd0;
            end
        end else if ((r_mode == MODE_DATA) && (r_s1_byte == BYTE_FF)) begin
            w_has_res = 1'b0;
        end else begin
            // plain data byte, or stuffed 0xFF 0x00 pair
            w_has_res = 1'b1;
            w_kind    = KIND_DATA;
            w_byte    = (r_mode == MODE_FF) ? BYTE_FF : r_s1_byte;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 16'd1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1_byte <= i_in_byte;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DATA;
            r_class  <= CLS_PREAMBLE;
            r_number <= 4'd0;
            r_pos    <= 16'd0;
        end else if (w_step) begin
            r_mode   <= n_mode;
            r_class  <= n_class;
            r_number <= n_number;
            r_pos    <= n_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_out_free) begin
            r_o_vld <= w_step && w_has_res;
        end
        if (w_step && w_has_res) begin
            r_o_kind   <= w_kind;
            r_o_class  <= w_class;
            r_o_number <= w_number;
            r_o_byte   <= w_byte;
            r_o_pos    <= w_pos;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_kind       = r_o_kind;
    assign o_seg_class  = r_o_class;
    assign o_seg_number = r_o_number;
    assign o_out_byte   = r_o_byte;
    assign o_byte_pos   = r_o_pos;

endmodule

// ----- src/jms_checker.sv -----
// port-level checks of the marker segmenter, bound to the top level
// depends on jms_pkg and jpeg_marker_segmenter_top_defines.svh
`timescale 1ns / 1ps
`include "jpeg_marker_segmenter_top_defines.svh"

module jms_checker
    import jms_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [3:0]  o_seg_class,
    input logic [3:0]  o_seg_number,
    input logic [7:0]  o_out_byte,
    input logic [15:0] o_byte_pos
);

    // marker results carry no position
    `JMS_ASSERT_NOW(a_mark_pos_zero, i_clk, i_rst_n,
        o_out_valid && (o_kind != KIND_DATA), o_byte_pos == 16'd0, "marker with nonzero position")

    // invalid markers and end of image carry no class or number
    `JMS_ASSERT_NOW(a_bad_eoi_cls, i_clk, i_rst_n,
        o_out_valid && ((o_kind == KIND_BAD) || (o_kind == KIND_EOI)),
        (o_seg_class == CLS_PREAMBLE) && (o_seg_number == 4'd0), "bad or eoi with class")

    // a valid marker always opens a real segment and is never the end-of-image code d9
    `JMS_ASSERT_NOW(a_mark_cls, i_clk, i_rst_n,
        o_out_valid && (o_kind == KIND_MARK),
        (o_seg_class != CLS_PREAMBLE) && (o_out_byte != CODE_EOI), "valid marker without class")

    // nothing follows the end-of-image transaction
    `JMS_ASSERT_NEXT(a_eoi_last, i_clk, i_rst_n,
        o_out_valid && i_out_ready && (o_kind == KIND_EOI), !o_out_valid, "result after eoi")

    // a stalled result holds
    `JMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_kind),
        "stalled result changed")

endmodule

bind jpeg_marker_segmenter_top jms_checker u_jms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_seg_class  (o_seg_class),
    .o_seg_number (o_seg_number),
    .o_out_byte   (o_out_byte),
    .o_byte_pos   (o_byte_pos)
);

// ----- test/tb_jpeg_marker_segmenter_top.sv -----
// testbench for jpeg_marker_segmenter_top: drives a byte stream, predicts each
// result in a scoreboard and compares it field by field with the block's output
// depends on jms_pkg and the jpeg_marker_segmenter_top rtl
`timescale 1ns / 1ps

module tb_jpeg_marker_segmenter_top;
    import jms_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 750;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 2_000_000;

    // one expected result transaction
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  seg_class;
        logic [3:0]  seg_number;
        logic [7:0]  out_byte;
        logic [15:0] byte_pos;
    } t_seg_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [3:0]  o_seg_class;
    logic [3:0]  o_seg_number;
    logic [7:0]  o_out_byte;
    logic [15:0] o_byte_pos;

    // parser state as predicted from the accepted bytes
    t_mode       scan_mode;
    logic [3:0]  seg_cls;
    logic [3:0]  seg_num;
    logic [15:0] seg_pos;

    t_seg_result seg_results_due[$];
    int          error_count  = 0;
    int          sent_count   = 0;
    logic        jitter_on    = 1'b1;
    logic        hold_pending = 1'b0;

    jpeg_marker_segmenter_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_seg_class  (o_seg_class),
        .o_seg_number (o_seg_number),
        .o_out_byte   (o_out_byte),
        .o_byte_pos   (o_byte_pos)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // marker code to segment class, unknown codes give preamble
    function automatic logic [3:0] marker_class(input logic [7:0] code,
                                                output logic [3:0] num);
        num = 4'd0;
        if (code >= CODE_RST0 && code <= CODE_RST0 + 8'd7) begin
            num = {1'b0, code[2:0]};
            return CLS_RST;
        end
        if (code >= CODE_APP0 && code <= CODE_APP0 + 8'd15) begin
            num = code[3:0];
            return CLS_APP;
        end
        case (code)
            CODE_SOI:  return CLS_SOI;
            CODE_SOF0: return CLS_SOF0;
            CODE_SOF2: return CLS_SOF2;
            CODE_DHT:  return CLS_DHT;
            CODE_DQT:  return CLS_DQT;
            CODE_DRI:  return CLS_DRI;
            CODE_SOS:  return CLS_SOS;
            CODE_COM:  return CLS_COM;
            default:   return CLS_PREAMBLE;
        endcase
    endfunction

    // append one predicted result transaction to the scoreboard
    task automatic queue_result(input t_kind kind, input logic [3:0] cls,
                                input logic [3:0] num, input logic [7:0] code,
                                input logic [15:0] pos);
        t_seg_result r;
        r.kind          = kind;
        r.seg_class     = cls;
        r.seg_number    = num;
        r.out_byte      = code;
        r.byte_pos      = pos;
        seg_results_due = {seg_results_due, r};
    endtask

    // data byte tagged with the open segment, position saturates
    task automatic push_data_result(input logic [7:0] b);
        queue_result(KIND_DATA, seg_cls, seg_num, b, seg_pos);
        if (seg_pos != POS_MAX) seg_pos = seg_pos + 16'd1;
    endtask

    // marker code byte: end of image, unknown or a new segment
    task automatic open_marker(input logic [7:0] code);
        logic [3:0] cls;
        logic [3:0] num;
        cls = marker_class(code, num);
        if (code == CODE_EOI) begin
            scan_mode = MODE_DONE;
            queue_result(KIND_EOI, 4'd0, 4'd0, code, 16'd0);
        end else if (cls == CLS_PREAMBLE) begin
            scan_mode = MODE_CODE;
            queue_result(KIND_BAD, 4'd0, 4'd0, code, 16'd0);
        end else begin
            scan_mode = MODE_DATA;
            seg_cls   = cls;
            seg_num   = num;
            seg_pos   = 16'd0;
            queue_result(KIND_MARK, cls, num, code, 16'd0);
        end
    endtask

    // advance the predicted parser by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        case (scan_mode)
            MODE_DATA: begin
                if (b == BYTE_FF) scan_mode = MODE_FF;
                else push_data_result(b);
            end
            MODE_FF: begin
                if (b == BYTE_00) begin
                    scan_mode = MODE_DATA;
                    push_data_result(BYTE_FF);
                end else begin
                    open_marker(b);
                end
            end
            MODE_CODE: open_marker(b);
            default: ;
        endcase
    endtask

    // offer one byte, hold it until the transaction, then predict
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (jitter_on && $urandom_range(0, 99) < 9) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        track_byte(b);
    endtask

    task automatic send_marker(input logic [7:0] code);
        send_byte(BYTE_FF);
        send_byte(code);
    endtask

    // keep the stream open: end of image only where the test asks for it
    function automatic logic [7:0] no_eoi(input logic [7:0] b);
        return (scan_mode != MODE_DATA && b == CODE_EOI) ? CODE_SOI : b;
    endfunction

    function automatic logic [7:0] pick_marker();
        case ($urandom_range(0, 9))
            0: return CODE_SOI;
            1: return CODE_SOF0;
            2: return CODE_SOF2;
            3: return CODE_DHT;
            4: return CODE_DQT;
            5: return CODE_DRI;
            6: return CODE_SOS;
            7: return CODE_COM;
            8: return CODE_RST0 + 8'($urandom_range(0, 7));
            default: return CODE_APP0 + 8'($urandom_range(0, 15));
        endcase
    endfunction

    // bytes before the first marker, stuffed ff and eoi code as plain data
    task automatic test_preamble();
        send_byte(BYTE_00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(CODE_EOI);
        send_byte(BYTE_FF);
        send_byte(BYTE_00);
    endtask

    // every known marker class, both ends of rst and app numbers
    task automatic test_marker_classes();
        send_marker(CODE_SOI);
        send_byte(8'h01);
        send_marker(CODE_SOF0);
        send_marker(CODE_SOF2);
        send_marker(CODE_DHT);
        send_byte(8'h55);
        send_marker(CODE_DQT);
        send_marker(CODE_DRI);
        send_marker(CODE_SOS);
        send_byte(8'hAA);
        send_byte(BYTE_FF);
        send_byte(BYTE_00);
        send_marker(CODE_COM);
        send_marker(CODE_RST0);
        send_marker(CODE_RST0 + 8'd7);
        send_byte(8'h33);
        send_marker(CODE_APP0);
        send_marker(CODE_APP0 + 8'd15);
        send_byte(8'h0F);
    endtask

    // unknown codes chain: 00 and ff right after one are codes too
    task automatic test_unknown_markers();
        send_marker(8'h01);
        send_byte(BYTE_00);
        send_byte(BYTE_FF);
        send_byte(CODE_DHT);
        send_byte(8'h12);
        send_marker(BYTE_FF);
        send_byte(CODE_SOI);
        send_byte(8'h13);
    endtask

    // mostly well-formed segments with random content, some noise and broken markers
    task automatic test_random_stream();
        int         stop_at;
        int         quiet_from;
        int         quiet_to;
        int         pick;
        logic [7:0] b;
        stop_at    = sent_count + RANDOM_ITEMS;
        quiet_from = sent_count + 300;
        quiet_to   = sent_count + 500;
        while (sent_count < stop_at) begin
            jitter_on = !(sent_count >= quiet_from && sent_count < quiet_to);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_marker(pick_marker());
                repeat ($urandom_range(0, 24)) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b);
                    if (b == BYTE_FF) send_byte(BYTE_00);
                end
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 4)) send_byte(no_eoi(8'($urandom_range(0, 255))));
            end else begin
                send_byte(BYTE_FF);
                send_byte(no_eoi(8'($urandom_range(0, 255))));
                send_byte(no_eoi(8'($urandom_range(0, 255))));
            end
        end
        jitter_on = 1'b1;
    endtask

    // receiver holds off for a long stretch while bytes keep coming
    task automatic test_input_backpressure();
        hold_pending = 1'b1;
        send_marker(pick_marker());
        repeat (40) send_byte(8'($urandom_range(0, 254)));
    endtask

    // end of image, then bytes that must all be swallowed
    task automatic test_end_of_image();
        send_marker(CODE_EOI);
        send_byte(BYTE_FF);
        send_byte(CODE_SOI);
        send_byte(CODE_EOI);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (jitter_on && $urandom_range(0, 99) < 9) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_seg_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (seg_results_due.size() == 0) begin
                $error("unexpected result: kind %0d, byte %h", o_kind, o_out_byte);
                error_count++;
            end else begin
                want = seg_results_due.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    error_count++;
                end
                if (o_seg_class !== want.seg_class) begin
                    $error("seg_class: expected %0d, got %0d", want.seg_class, o_seg_class);
                    error_count++;
                end
                if (o_seg_number !== want.seg_number) begin
                    $error("seg_number: expected %0d, got %0d", want.seg_number, o_seg_number);
                    error_count++;
                end
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_out_byte);
                    error_count++;
                end
                if (o_byte_pos !== want.byte_pos) begin
                    $error("byte_pos: expected %0d, got %0d", want.byte_pos, o_byte_pos);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_jpeg_marker_segmenter_top: done, errors");
        $finish;
    end

    // test sequence
    initial begin
        int waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = 8'h00;
        scan_mode  = MODE_DATA;
        seg_cls    = CLS_PREAMBLE;
        seg_num    = 4'd0;
        seg_pos    = 16'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preamble();
        test_marker_classes();
        test_unknown_markers();
        test_random_stream();
        test_input_backpressure();
        test_end_of_image();
        i_in_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        waited = 0;
        while (seg_results_due.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (seg_results_due.size() > 0) begin
            $error("%0d expected results never arrived", seg_results_due.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("tb_jpeg_marker_segmenter_top: done, clean");
        end else begin
            $display("tb_jpeg_marker_segmenter_top: done, errors");
        end
        $finish;
    end

endmodule
